// File: rtl/core/tgr_pkg.sv
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types, constants, font table and clipping helper of the glyph renderer.
// ----------------------------------------------------------------------------
package tgr_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 160;

    localparam logic       OP_RENDER     = 1'b0;
    localparam logic       OP_SET_CURSOR = 1'b1;
    localparam logic [7:0] CHAR_NEWLINE  = 8'd10;
    localparam logic [7:0] CHAR_FIRST    = 8'd32;
    localparam logic [7:0] CHAR_LAST     = 8'd126;
    localparam logic [7:0] CHAR_QUESTION = 8'd63;

    localparam logic [2:0] LAST_COL = 3'd4;
    localparam logic [2:0] LAST_ROW = 3'd6;

    localparam logic REG_TEXT_COLOR = 1'b0;
    localparam logic REG_TEXT_SIZE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } tgr_state_t;

    typedef struct packed {
        logic set_cursor;
        logic newline;
        logic start_glyph;
        logic step;
        logic flush;
    } tgr_cmd_t;

    typedef struct packed {
        logic in_set_cursor;
        logic in_newline;
        logic can_push;
        logic scan_last;
    } tgr_status_t;

    typedef struct packed {
        logic       vis;
        logic [8:0] lo;
        logic [8:0] len;
    } tgr_span_t;

    // Intersects [start, start+size) with [0, limit).
    function automatic tgr_span_t clip_span(input logic signed [15:0] start,
                                            input logic [7:0] size,
                                            input logic [8:0] limit);
        logic signed [17:0] s;
        logic signed [17:0] e;
        logic signed [17:0] a;
        logic signed [17:0] b;
        logic signed [17:0] d;
        tgr_span_t          r;
        s = 18'(start);
        e = s + $signed({10'd0, size});
        a = (s < 0) ? 18'sd0 : s;
        b = (e > $signed({9'd0, limit})) ? $signed({9'd0, limit}) : e;
        d = b - a;
        r.vis = (b > a);
        r.lo  = a[8:0];
        r.len = d[8:0];
        return r;
    endfunction

    // Five column bytes per code, column 0 in the top byte; bit 0 is the top row.
    localparam logic [39:0] GLYPH_ROM [95] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700,
        40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
        40'h3649552250, 40'h0005030000, 40'h001C224100,
        40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
        40'h4261514946, 40'h2141454B31, 40'h1814127F10,
        40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000,
        40'h0056360000, 40'h0008142241, 40'h1414141414,
        40'h4122140800, 40'h0201510906, 40'h324979413E,
        40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
        40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
        40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
        40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
        40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
        40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204,
        40'h4040404040, 40'h0001020400, 40'h2054545478,
        40'h7F48444438, 40'h3844444420, 40'h384444487F,
        40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
        40'h7C08040478, 40'h3844444438, 40'h7C14141408,
        40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040407C, 40'h1C2040201C,
        40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44, 40'h0008364100, 40'h00007F0000,
        40'h0041360800, 40'h08082A1C08
    };

endpackage

// File: rtl/core/text_glyph_renderer.sv
// ----------------------------------------------------------------------------
// text_glyph_renderer
// Draws 5x7 font characters at a text cursor as clipped filled squares.
// ----------------------------------------------------------------------------
// The slave stream takes one command per beat: s_tuser selects render
// character or set cursor, s_tdata carries the character and new cursor.
// A rendered character scans its 35 font dots, one dot per cycle unless the
// output stalls, and sends one master beat per visible square; m_tlast marks
// the final square. s_tready stays low while a character is in progress, so
// the next character waits until it is done: the accepting cycle loads the
// glyph, then come the 35 dot scans and the flush. A newline or set cursor
// is handled in the accepting cycle and sends nothing.
// Each square is held until the next visible dot or the flush shows whether
// it is the last, and leaves on the cycle after that; the final square leaves
// on the cycle after the flush. When the receiver stalls, the scan halts with
// the output beat held. Reset clears the cursor, sets the color to white and
// the size to one.
// text_color and text_size sit at APB byte addresses 0 and 4; the user must
// write them only while no character is in progress; it is not enforced.
// ----------------------------------------------------------------------------
module text_glyph_renderer
    import tgr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // char_code, new_cursor_x, new_cursor_y
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // rect_x, rect_y, rect_width, rect_height, rect_color
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] text_color_reg;
    logic [7:0]  text_size_reg;
    logic        cfg_wr;
    tgr_cmd_t    cmd;
    tgr_status_t status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg <= 16'hFFFF;
            text_size_reg  <= 8'd1;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_TEXT_COLOR) begin
                text_color_reg <= pwdata[15:0];
            end else begin
                text_size_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_TEXT_SIZE) ? {24'd0, text_size_reg}
                                                : {16'd0, text_color_reg};

    tgr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tgr_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .text_color (text_color_reg),
        .text_size  (text_size_reg),
        .cmd        (cmd),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    a_rect_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[22:15] != 8'd0) && (m_tdata[30:23] != 8'd0))
        else $error("empty square emitted");

    a_rect_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:7] < 8'(SCREEN_HEIGHT)))
        else $error("square row off screen");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

endmodule

// File: rtl/core/tgr_ctrl.sv
// ----------------------------------------------------------------------------
// tgr_ctrl
// Sequencer that decodes each input beat and steps the dot scan.
// ----------------------------------------------------------------------------
module tgr_ctrl
    import tgr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  tgr_status_t status,
    output tgr_cmd_t    cmd
);

    tgr_state_t state_reg;
    tgr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (status.in_set_cursor) begin
                        cmd.set_cursor = 1'b1;
                    end else if (status.in_newline) begin
                        cmd.newline = 1'b1;
                    end else begin
                        cmd.start_glyph = 1'b1;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (status.can_push) begin
                    cmd.step = 1'b1;
                    if (status.scan_last) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (status.can_push) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/tgr_datapath.sv
// ----------------------------------------------------------------------------
// tgr_datapath
// Cursor, glyph scan counters, square clipping and the output register.
// ----------------------------------------------------------------------------
module tgr_datapath
    import tgr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic [15:0] text_color,
    input  logic [7:0]  text_size,
    input  tgr_cmd_t    cmd,
    output tgr_status_t status,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic        m_tlast
);

    logic [15:0] cur_col_reg;
    logic [15:0] cur_row_reg;
    logic [39:0] glyph_reg;
    logic [2:0]  col_reg;
    logic [2:0]  row_reg;
    logic [9:0]  xoff_reg;
    logic [10:0] yoff_reg;
    logic        pend_valid_reg;
    logic [46:0] pend_reg;
    logic        m_valid_reg;
    logic [46:0] m_data_reg;
    logic        m_last_reg;

    logic [7:0]  char_code;
    logic [7:0]  size_eff;
    logic [6:0]  glyph_idx;
    logic [7:0]  col_byte;
    logic        dot;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    tgr_span_t   span_x;
    tgr_span_t   span_y;
    logic        visible;
    logic [46:0] square;

    assign char_code = s_tdata[7:0];
    assign size_eff  = (text_size == 8'd0) ? 8'd1 : text_size;

    always_comb begin
        if (char_code < CHAR_FIRST || char_code > CHAR_LAST) begin
            glyph_idx = 7'(CHAR_QUESTION - CHAR_FIRST);
        end else begin
            glyph_idx = 7'(char_code - CHAR_FIRST);
        end
    end

    assign col_byte = glyph_reg[(5'(LAST_COL - col_reg)) * 8 +: 8];
    assign dot      = col_byte[row_reg];
    assign x_pos    = cur_col_reg + {6'd0, xoff_reg};
    assign y_pos    = cur_row_reg + {5'd0, yoff_reg};
    assign span_x   = clip_span(x_pos, size_eff, 9'(SCREEN_WIDTH));
    assign span_y   = clip_span(y_pos, size_eff, 9'(SCREEN_HEIGHT));
    assign visible  = dot && span_x.vis && span_y.vis;
    assign square   = {text_color, span_y.len[7:0], span_x.len[7:0],
                       span_y.lo[7:0], span_x.lo[6:0]};

    assign status.in_set_cursor = (s_tuser == OP_SET_CURSOR);
    assign status.in_newline    = (char_code == CHAR_NEWLINE);
    assign status.can_push      = !m_valid_reg || m_tready;
    assign status.scan_last     = (col_reg == LAST_COL) && (row_reg == LAST_ROW);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
        end else if (cmd.set_cursor) begin
            cur_col_reg <= s_tdata[23:8];
            cur_row_reg <= s_tdata[39:24];
        end else if (cmd.newline) begin
            cur_col_reg <= '0;
            cur_row_reg <= cur_row_reg + {5'd0, size_eff, 3'd0};
        end else if (cmd.flush) begin
            cur_col_reg <= cur_col_reg + {6'd0, size_eff, 2'd0} + {7'd0, size_eff, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_glyph) begin
            glyph_reg <= GLYPH_ROM[glyph_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            xoff_reg <= '0;
            yoff_reg <= '0;
        end else if (cmd.start_glyph) begin
            col_reg  <= '0;
            row_reg  <= '0;
            xoff_reg <= '0;
            yoff_reg <= '0;
        end else if (cmd.step) begin
            if (row_reg == LAST_ROW) begin
                row_reg  <= '0;
                yoff_reg <= '0;
                col_reg  <= col_reg + 3'd1;
                xoff_reg <= xoff_reg + {2'd0, size_eff};
            end else begin
                row_reg  <= row_reg + 3'd1;
                yoff_reg <= yoff_reg + {3'd0, size_eff};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.step && visible) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.flush) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && visible) begin
            pend_reg <= square;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((cmd.step && visible && pend_valid_reg) ||
                     (cmd.flush && pend_valid_reg)) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((cmd.step && visible) || cmd.flush) begin
            m_data_reg <= pend_reg;
            m_last_reg <= cmd.flush;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};
    assign m_tlast  = m_last_reg;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream testbench for the glyph renderer: it drives commands in bursts,
// predicts the clipped squares of every glyph and checks each output beat.
// ----------------------------------------------------------------------------
module testbench;
    import tgr_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic        op;
        logic [7:0]  code;
        logic [15:0] x;
        logic [15:0] y;
    } command_t;

    typedef struct {
        logic [6:0]  rx;
        logic [7:0]  ry;
        logic [7:0]  rw;
        logic [7:0]  rh;
        logic [15:0] color;
        logic        last;
    } square_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    command_t    pending_cmds[$];
    square_t     expected_squares[$];
    logic [15:0] cur_col = '0;
    logic [15:0] cur_row = '0;
    logic [15:0] cfg_color = 16'hFFFF;
    logic [7:0]  cfg_size = 8'd1;
    int          errors = 0;
    int          cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    logic [15:0] stall_pattern = '1;

    text_glyph_renderer dut (.*);

    always #6 aclk = ~aclk;

    function automatic void draw_glyph(input command_t cmd);
        logic [7:0]  code;
        logic [7:0]  sz;
        logic [39:0] bits;
        logic [7:0]  colbyte;
        logic [15:0] px;
        logic [15:0] py;
        int          x0, y0, xa, xb, ya, yb, count;
        int          szi;
        square_t     sq;
        sz = (cfg_size == 0) ? 8'd1 : cfg_size;
        szi = int'(sz);
        if (cmd.op == OP_SET_CURSOR) begin
            cur_col = cmd.x;
            cur_row = cmd.y;
            return;
        end
        if (cmd.code == CHAR_NEWLINE) begin
            cur_col = '0;
            cur_row = cur_row + 16'(8 * sz);
            return;
        end
        code = (cmd.code < CHAR_FIRST || cmd.code > CHAR_LAST) ? CHAR_QUESTION : cmd.code;
        bits = GLYPH_ROM[code - CHAR_FIRST];
        count = 0;
        for (int c = 0; c < 5; c++) begin
            colbyte = bits[39 - 8 * c -: 8];
            for (int r = 0; r < 7; r++) begin
                if (colbyte[r]) begin
                    px = cur_col + 16'(c * sz);
                    py = cur_row + 16'(r * sz);
                    x0 = $signed(px);
                    y0 = $signed(py);
                    xa = (x0 < 0) ? 0 : x0;
                    xb = (x0 + szi > SCREEN_WIDTH) ? SCREEN_WIDTH : x0 + szi;
                    ya = (y0 < 0) ? 0 : y0;
                    yb = (y0 + szi > SCREEN_HEIGHT) ? SCREEN_HEIGHT : y0 + szi;
                    if (xb > xa && yb > ya) begin
                        sq.rx = 7'(xa);
                        sq.ry = 8'(ya);
                        sq.rw = 8'(xb - xa);
                        sq.rh = 8'(yb - ya);
                        sq.color = cfg_color;
                        sq.last = 1'b0;
                        expected_squares.push_back(sq);
                        count++;
                    end
                end
            end
        end
        if (count > 0) expected_squares[expected_squares.size() - 1].last = 1'b1;
        cur_col = cur_col + 16'(6 * sz);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Command driver with bursts and gaps.
    always @(posedge aclk) begin
        command_t cmd;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                cmd.op = s_tuser;
                cmd.code = s_tdata[7:0];
                cmd.x = s_tdata[23:8];
                cmd.y = s_tdata[39:24];
                draw_glyph(cmd);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || pending_cmds.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                end else begin
                    cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= cmd.op;
                    s_tdata <= {cmd.y, cmd.x, cmd.code};
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // Square monitor with its own stall pattern.
    always @(posedge aclk) begin
        square_t sq;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (cycles % 97 == 0)
                stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            m_tready <= stall_pattern[cycles % 16];
            if (m_tvalid && m_tready) begin
                if (expected_squares.size() == 0) begin
                    $error("unexpected square beat %h", m_tdata);
                    errors = errors + 1;
                end else begin
                    sq = expected_squares.pop_front();
                    if (m_tdata[6:0] !== sq.rx) begin
                        $error("rect_x exp %0d got %0d", sq.rx, m_tdata[6:0]);
                        errors = errors + 1;
                    end
                    if (m_tdata[14:7] !== sq.ry) begin
                        $error("rect_y exp %0d got %0d", sq.ry, m_tdata[14:7]);
                        errors = errors + 1;
                    end
                    if (m_tdata[22:15] !== sq.rw) begin
                        $error("rect_width exp %0d got %0d", sq.rw, m_tdata[22:15]);
                        errors = errors + 1;
                    end
                    if (m_tdata[30:23] !== sq.rh) begin
                        $error("rect_height exp %0d got %0d", sq.rh, m_tdata[30:23]);
                        errors = errors + 1;
                    end
                    if (m_tdata[46:31] !== sq.color) begin
                        $error("rect_color exp %h got %h", sq.color, m_tdata[46:31]);
                        errors = errors + 1;
                    end
                    if (m_tlast !== sq.last) begin
                        $error("last_of_glyph exp %0b got %0b", sq.last, m_tlast);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

    task automatic put_char(input logic [7:0] code);
        command_t cmd;
        cmd.op = OP_RENDER;
        cmd.code = code;
        cmd.x = 16'($urandom);
        cmd.y = 16'($urandom);
        pending_cmds.push_back(cmd);
    endtask

    task automatic put_cursor(input logic [15:0] x, input logic [15:0] y);
        command_t cmd;
        cmd.op = OP_SET_CURSOR;
        cmd.code = 8'($urandom);
        cmd.x = x;
        cmd.y = y;
        pending_cmds.push_back(cmd);
    endtask

    task automatic drain();
        wait (pending_cmds.size() == 0 && !s_tvalid);
        wait (expected_squares.size() == 0);
        repeat (45) @(posedge aclk);
    endtask

    task automatic write_reg(input logic index, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == REG_TEXT_COLOR) cfg_color = value[15:0];
        else cfg_size = value[7:0];
    endtask

    task automatic random_phase(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 19);
            if (k < 12) put_char(8'($urandom_range(32, 126)));
            else if (k < 14) put_char(8'($urandom));
            else if (k < 15) put_char(CHAR_NEWLINE);
            else if (k < 19)
                put_cursor(16'($signed($urandom_range(0, 170)) - 20),
                           16'($signed($urandom_range(0, 200)) - 20));
            else put_cursor(16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        put_cursor(16'd0, 16'd0);
        put_char("A");
        put_char(8'd0);
        put_char(8'd255);
        put_char(8'd127);
        put_char(8'd31);
        put_char(CHAR_FIRST);
        put_char(CHAR_LAST);
        put_char(CHAR_NEWLINE);
        put_char("8");
        put_cursor(-16'sd3, -16'sd2);
        put_char("#");
        put_cursor(16'd125, 16'd157);
        put_char("W");
        put_cursor(16'h7FFF, 16'h7FFF);
        put_char("M");
        put_char("M");
        put_cursor(16'h8000, 16'h8000);
        put_char(CHAR_NEWLINE);
        put_cursor(16'hFFFC, 16'd150);
        put_char("@");
        drain();

        write_reg(REG_TEXT_SIZE, 32'd0);
        write_reg(REG_TEXT_COLOR, 32'h0000);
        random_phase(30);
        drain();

        write_reg(REG_TEXT_SIZE, 32'd255);
        write_reg(REG_TEXT_COLOR, 32'hFFFF);
        put_cursor(16'd0, 16'd0);
        put_char("B");
        put_cursor(-16'sd200, -16'sd300);
        put_char("H");
        put_char(CHAR_NEWLINE);
        random_phase(6);
        drain();

        write_reg(REG_TEXT_SIZE, 32'd2);
        write_reg(REG_TEXT_COLOR, $urandom);
        random_phase(20);
        drain();

        write_reg(REG_TEXT_SIZE, 32'($urandom_range(3, 40)));
        write_reg(REG_TEXT_COLOR, $urandom);
        random_phase(25);
        drain();

        write_reg(REG_TEXT_SIZE, 32'd1);
        write_reg(REG_TEXT_COLOR, 32'hA5A5);
        random_phase(25);
        drain();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
